@@ src/tcsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tcsr_pkg
// Shared types and constants of the scaled text-cell renderer: request and
// result payloads, request kinds, palette bases and default geometry.
// ----------------------------------------------------------------------------
package tcsr_pkg;

    // Default geometry
    localparam int DEF_CELLS_PER_ROW          = 80;
    localparam int DEF_ROWS                   = 25;
    localparam int DEF_LINES_PER_CHAR         = 14;
    localparam int DEF_GLYPH_COUNT            = 512;
    localparam int DEF_SURFACE_WORDS_PER_LINE = 128;

    // Palette layout
    localparam logic [7:0] NORMAL_BASE    = 8'd16;
    localparam logic [7:0] PROTECTED_BASE = NORMAL_BASE + 8'd16 + 8'd120;

    // Glyph and color masks
    localparam logic [8:0] CHAR_MASK      = 9'h1FF;
    localparam logic [3:0] COLOR_MASK     = 4'hF;
    localparam int         PROTECTED_BIT  = 8;

    // Width of the cache generation mark kept next to each cached key
    localparam int EPOCH_W = 8;

    typedef enum logic [1:0] {
        KIND_CELL  = 2'd0,
        KIND_GLYPH = 2'd1,
        KIND_MIX   = 2'd2,
        KIND_INVAL = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [10:0] cell_index;
        logic [15:0] char_code;
        logic [7:0]  back_color;
        logic [7:0]  fore_color;
        logic [8:0]  glyph_char;
        logic [3:0]  glyph_line;
        logic [7:0]  glyph_byte;
        logic [7:0]  table_index;
        logic [7:0]  table_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0] word_address;
        logic [31:0] four_pixels;
        logic        last_line;
    } out_item_t;

endpackage

@@ src/text_cell_scaled_renderer.sv @@
// ----------------------------------------------------------------------------
// text_cell_scaled_renderer
// Renders text cells into a half-width 8-bit bitmap, one 32-bit word of four
// pixels per glyph line, skipping cells whose key matches the cell cache.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. A glyph write, a mix table write or a
// cache invalidate is carried out when it is accepted. A cell outside the
// screen is dropped, a cell that hits the cache is skipped after the lookup,
// and a cell that renders goes through lookup, row/column split and
// address setup, then one glyph line per cycle from the single read port of
// the glyph store, slowed only by backpressure on the result channel. The
// last result may still wait in the output register while the next request
// is taken. Cache validity is a generation mark stored with each key; after
// reset, and again after every 255th invalidation or glyph write, a clearing
// pass over all CELLS_PER_ROW * ROWS entries sweeps the key cache while
// in_ready stays low. cache_enable writes are taken at any time.
// ----------------------------------------------------------------------------
module text_cell_scaled_renderer
    import tcsr_pkg::*;
#(
    parameter int CELLS_PER_ROW          = DEF_CELLS_PER_ROW,
    parameter int ROWS                   = DEF_ROWS,
    parameter int LINES_PER_CHAR         = DEF_LINES_PER_CHAR,
    parameter int GLYPH_COUNT            = DEF_GLYPH_COUNT,
    parameter int SURFACE_WORDS_PER_LINE = DEF_SURFACE_WORDS_PER_LINE
)
(
    input  logic      clk,
    input  logic      rst_n,

    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,

    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,

    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data
);

    localparam int CELL_TOTAL  = CELLS_PER_ROW * ROWS;
    localparam int GLYPH_BYTES = GLYPH_COUNT * LINES_PER_CHAR;
    localparam int CELL_AW     = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
    localparam int GLYPH_AW    = (GLYPH_BYTES > 1) ? $clog2(GLYPH_BYTES) : 1;
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W       = (CELLS_PER_ROW > 1) ? $clog2(CELLS_PER_ROW) : 1;
    localparam int LINE_W      = $clog2(LINES_PER_CHAR + 1);
    localparam int ROW_WORDS   = LINES_PER_CHAR * SURFACE_WORDS_PER_LINE;

    // Row = (index * RECIP) >> DIV_SHIFT, exact for any 11-bit index
    localparam int IDX_W     = 11;
    localparam int DIV_SHIFT = IDX_W + $clog2(CELLS_PER_ROW);
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = IDX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** DIV_SHIFT) + CELLS_PER_ROW - 1) / CELLS_PER_ROW);

    localparam logic [13:0]         CELL_TOTAL_W = 14'(CELL_TOTAL);
    localparam logic [9:0]          GLYPH_COUNT_W = 10'(GLYPH_COUNT);
    localparam logic [4:0]          LINES_W5 = 5'(LINES_PER_CHAR);
    localparam logic [LINE_W-1:0]   LINES_CNT = LINE_W'(LINES_PER_CHAR);
    localparam logic [LINE_W-1:0]   LAST_LINE = LINE_W'(LINES_PER_CHAR - 1);
    localparam logic [CELL_AW-1:0]  CLR_LAST = CELL_AW'(CELL_TOTAL - 1);
    localparam logic [EPOCH_W-1:0]  EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0]  EPOCH_LAST = {EPOCH_W{1'b1}};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SPLIT,
        ST_BASE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [31:0]        key;
    } key_entry_t;

    function automatic logic [7:0] normal_blend(input logic [3:0] bg, input logic [3:0] fg);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] am1;
        logic [7:0] tri_v;
        logic [7:0] res;
        a     = (bg < fg) ? {4'b0, bg} : {4'b0, fg};
        b     = (bg < fg) ? {4'b0, fg} : {4'b0, bg};
        am1   = (a == 8'd0) ? 8'd0 : a - 8'd1;
        tri_v = 8'((a * am1) >> 1);
        if (a == b)
        begin
            res = NORMAL_BASE + a;
        end
        else
        begin
            res = NORMAL_BASE + 8'd16 + 8'(a * 8'd15) - tri_v + (b - a - 8'd1);
        end
        return res;
    endfunction

    // Memories
    key_entry_t key_mem   [CELL_TOTAL];
    logic [7:0] glyph_mem [GLYPH_BYTES];
    logic [7:0] mix_mem   [256];

    key_entry_t          kc_rdata_reg;
    logic [7:0]          gl_rdata_reg;
    logic [7:0]          mix_rdata_reg;

    logic                kc_re;
    logic                kc_we;
    logic [CELL_AW-1:0]  kc_raddr;
    logic [CELL_AW-1:0]  kc_waddr;
    key_entry_t          kc_wdata;
    logic                gl_re;
    logic                gl_we;
    logic [GLYPH_AW-1:0] gl_waddr;
    logic                mix_re;
    logic                mix_we;
    logic [7:0]          mix_addr;

    // Control state
    state_t              state_reg, state_next;
    logic                cache_en_reg, cache_en_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [CELL_AW-1:0]  clr_addr_reg, clr_addr_next;
    logic [LINE_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic [LINE_W-1:0]   emit_cnt_reg, emit_cnt_next;
    logic                gd_valid_reg, gd_valid_next;
    logic                out_valid_reg, out_valid_next;

    // Payload
    in_item_t            item_reg, item_next;
    logic [ROW_W-1:0]    row_q_reg, row_q_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [15:0]         line_addr_reg, line_addr_next;
    logic [GLYPH_AW-1:0] glyph_addr_reg, glyph_addr_next;
    logic                glyph_ok_reg, glyph_ok_next;
    logic [7:0]          pal0_reg, pal0_next;
    logic [7:0]          pal1_reg, pal1_next;
    logic [7:0]          pal3_reg, pal3_next;
    out_item_t           out_data_reg, out_data_next;

    // Datapath helpers
    logic                accept;
    logic                cell_in_range;
    logic                glyph_wr_ok;
    logic [31:0]         item_key;
    logic                cache_hit;
    logic [PROD_W-1:0]   div_prod;
    logic [IDX_W-1:0]    col_raw;
    logic [8:0]          chr;
    logic [3:0]          bg4;
    logic [3:0]          fg4;
    logic                can_load;
    logic                consume;
    logic                issue;
    logic [7:0]          glyph_bits;
    logic [31:0]         pixels;

    function automatic logic [7:0] pick(input logic [1:0] pair, input logic [7:0] p0,
                                        input logic [7:0] p1, input logic [7:0] p3);
        logic [7:0] res;
        unique case (pair)
            2'b00:   res = p0;
            2'b11:   res = p3;
            default: res = p1;
        endcase
        return res;
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign accept        = in_valid && in_ready;
    assign cell_in_range = {3'b000, in_data.cell_index} < CELL_TOTAL_W;
    assign glyph_wr_ok   = ({1'b0, in_data.glyph_char} < GLYPH_COUNT_W)
                        && ({1'b0, in_data.glyph_line} < LINES_W5);

    assign chr      = item_reg.char_code[8:0] & CHAR_MASK;
    assign bg4      = item_reg.back_color[3:0] & COLOR_MASK;
    assign fg4      = item_reg.fore_color[3:0] & COLOR_MASK;
    assign item_key = {item_reg.fore_color, item_reg.back_color, item_reg.char_code};
    assign cache_hit = cache_en_reg && (kc_rdata_reg.epoch == epoch_reg)
                    && (kc_rdata_reg.key == item_key);

    assign div_prod = PROD_W'(item_reg.cell_index) * PROD_W'(RECIP);
    assign col_raw  = item_reg.cell_index - (IDX_W'(row_q_reg) * IDX_W'(CELLS_PER_ROW));

    assign can_load   = !out_valid_reg || out_ready;
    assign consume    = gd_valid_reg && can_load;
    assign issue      = (state_reg == ST_EMIT) && (issue_cnt_reg != LINES_CNT)
                     && (!gd_valid_reg || consume);
    assign glyph_bits = glyph_ok_reg ? gl_rdata_reg : 8'd0;
    assign pixels     = {pick(glyph_bits[1:0], pal0_reg, pal1_reg, pal3_reg),
                         pick(glyph_bits[3:2], pal0_reg, pal1_reg, pal3_reg),
                         pick(glyph_bits[5:4], pal0_reg, pal1_reg, pal3_reg),
                         pick(glyph_bits[7:6], pal0_reg, pal1_reg, pal3_reg)};

    // Memory port control
    always_comb
    begin
        kc_re    = accept && (in_data.kind == KIND_CELL) && cell_in_range;
        kc_raddr = CELL_AW'(in_data.cell_index);
        kc_we    = 1'b0;
        kc_waddr = CELL_AW'(item_reg.cell_index);
        kc_wdata = '{epoch: epoch_reg, key: item_key};
        if (state_reg == ST_CLEAR)
        begin
            kc_we    = 1'b1;
            kc_waddr = clr_addr_reg;
            kc_wdata = '{epoch: '0, key: '0};
        end
        else if ((state_reg == ST_CHECK) && !cache_hit)
        begin
            kc_we = 1'b1;
        end

        gl_we    = accept && (in_data.kind == KIND_GLYPH) && glyph_wr_ok;
        gl_waddr = GLYPH_AW'(GLYPH_AW'(in_data.glyph_char) * GLYPH_AW'(LINES_PER_CHAR)
                 + GLYPH_AW'(in_data.glyph_line));
        gl_re    = issue;

        mix_we   = accept && (in_data.kind == KIND_MIX);
        mix_re   = accept && (in_data.kind == KIND_CELL);
        mix_addr = mix_we ? in_data.table_index
                          : {in_data.back_color[3:0] & COLOR_MASK,
                             in_data.fore_color[3:0] & COLOR_MASK};
    end

    always_ff @(posedge clk)
    begin
        if (kc_we)
        begin
            key_mem[kc_waddr] <= kc_wdata;
        end
        if (kc_re)
        begin
            kc_rdata_reg <= key_mem[kc_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (gl_we)
        begin
            glyph_mem[gl_waddr] <= in_data.glyph_byte;
        end
        if (gl_re)
        begin
            gl_rdata_reg <= glyph_mem[glyph_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mix_we)
        begin
            mix_mem[mix_addr] <= in_data.table_value;
        end
        if (mix_re)
        begin
            mix_rdata_reg <= mix_mem[mix_addr];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cache_en_next   = cfg_wr_en ? cfg_wr_data : cache_en_reg;
        epoch_next      = epoch_reg;
        clr_addr_next   = clr_addr_reg;
        issue_cnt_next  = issue_cnt_reg;
        emit_cnt_next   = emit_cnt_reg;
        gd_valid_next   = gd_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        item_next       = item_reg;
        row_q_next      = row_q_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        line_addr_next  = line_addr_reg;
        glyph_addr_next = glyph_addr_reg;
        glyph_ok_next   = glyph_ok_reg;
        pal0_next       = pal0_reg;
        pal1_next       = pal1_reg;
        pal3_next       = pal3_reg;
        out_data_next   = out_data_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + CELL_AW'(1);
                if (clr_addr_reg == CLR_LAST)
                begin
                    clr_addr_next = '0;
                    epoch_next    = EPOCH_FIRST;
                    state_next    = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_data;
                    unique case (in_data.kind)
                        KIND_CELL:
                        begin
                            // drop cells outside the screen
                            if (cell_in_range)
                            begin
                                state_next = ST_CHECK;
                            end
                        end
                        KIND_GLYPH, KIND_INVAL:
                        begin
                            if ((in_data.kind == KIND_INVAL) || glyph_wr_ok)
                            begin
                                // advance the generation; sweep once it runs out
                                if (epoch_reg == EPOCH_LAST)
                                begin
                                    state_next = ST_CLEAR;
                                end
                                else
                                begin
                                    epoch_next = epoch_reg + EPOCH_W'(1);
                                end
                            end
                        end
                        KIND_MIX:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_CHECK:
            begin
                if (cache_hit)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    row_q_next      = ROW_W'(div_prod >> DIV_SHIFT);
                    glyph_addr_next = GLYPH_AW'(GLYPH_AW'(chr) * GLYPH_AW'(LINES_PER_CHAR));
                    glyph_ok_next   = {1'b0, chr} < GLYPH_COUNT_W;
                    if (chr[PROTECTED_BIT])
                    begin
                        pal0_next = PROTECTED_BASE + {4'b0, bg4};
                        pal3_next = PROTECTED_BASE + {4'b0, fg4};
                        pal1_next = mix_rdata_reg;
                    end
                    else
                    begin
                        pal0_next = NORMAL_BASE + {4'b0, bg4};
                        pal3_next = NORMAL_BASE + {4'b0, fg4};
                        pal1_next = normal_blend(bg4, fg4);
                    end
                    state_next = ST_SPLIT;
                end
            end

            ST_SPLIT:
            begin
                if (col_raw >= IDX_W'(CELLS_PER_ROW))
                begin
                    row_next = row_q_reg + ROW_W'(1);
                    col_next = COL_W'(col_raw - IDX_W'(CELLS_PER_ROW));
                end
                else
                begin
                    row_next = row_q_reg;
                    col_next = COL_W'(col_raw);
                end
                state_next = ST_BASE;
            end

            ST_BASE:
            begin
                line_addr_next = 16'(row_reg * 16'(ROW_WORDS)) + 16'(col_reg);
                issue_cnt_next = '0;
                emit_cnt_next  = '0;
                gd_valid_next  = 1'b0;
                state_next     = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (issue)
                begin
                    glyph_addr_next = glyph_addr_reg + GLYPH_AW'(1);
                    issue_cnt_next  = issue_cnt_reg + LINE_W'(1);
                    gd_valid_next   = 1'b1;
                end
                else if (consume)
                begin
                    gd_valid_next = 1'b0;
                end
                if (consume)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{word_address: line_addr_reg,
                                       four_pixels:  pixels,
                                       last_line:    emit_cnt_reg == LAST_LINE};
                    line_addr_next = line_addr_reg + 16'(SURFACE_WORDS_PER_LINE);
                    emit_cnt_next  = emit_cnt_reg + LINE_W'(1);
                    if (emit_cnt_reg == LAST_LINE)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cache_en_reg  <= 1'b1;
            epoch_reg     <= '0;
            clr_addr_reg  <= '0;
            issue_cnt_reg <= '0;
            emit_cnt_reg  <= '0;
            gd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cache_en_reg  <= cache_en_next;
            epoch_reg     <= epoch_next;
            clr_addr_reg  <= clr_addr_next;
            issue_cnt_reg <= issue_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            gd_valid_reg  <= gd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        row_q_reg      <= row_q_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        line_addr_reg  <= line_addr_next;
        glyph_addr_reg <= glyph_addr_next;
        glyph_ok_reg   <= glyph_ok_next;
        pal0_reg       <= pal0_next;
        pal1_reg       <= pal1_next;
        pal3_reg       <= pal3_next;
        out_data_reg   <= out_data_next;
    end

endmodule
